### rtl/glzw_pkg.sv
// Package for the GIF LZW pixel decoder: sizes, register indexes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package glzw_pkg;
	localparam int TableDepth = 4096;
	localparam int AddrW = 12;
	localparam int MaxCodeBits = 12;
	localparam logic [11:0] Mask12 = 12'hFFF;

	typedef enum logic [1:0] {
		REG_MIN = 2'd0,
		REG_WIDTH = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_CLIP = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOP,
		ST_RDWAIT,
		ST_WALK,
		ST_POPWAIT,
		ST_DONE
	} state_t;

	function automatic logic [3:0] eff_min(input logic [3:0] m);
		if (m < 4'd2) return 4'd2;
		if (m > 4'd8) return 4'd8;
		return m;
	endfunction
endpackage

### rtl/gif_lzw_pixel_decoder_unit.sv
// GIF LZW pixel decoder: byte feed, code extraction, prefix-chain walk, pixel tagging.
// A feed stores one length or data byte; a fetch pops one pixel from the stack, and when
// the stack is empty it first reads codes, consuming clear and end codes, and decodes one
// code by walking its prefix chain with one dictionary read per link.
// One item in flight; the result waits in an output register and the next transaction
// is taken the cycle after it leaves. Reset (arst_n low) sets all registers; memories are not cleared.
`timescale 1ns / 1ps
module gif_lzw_pixel_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] pixel_valid, [8:1] pixel, [9] visible,
	                               // [10] row_end, [11] image_end, [12] need_byte,
	                               // [13] byte_taken, [15:14] zero
	output logic        m_tuser    // unused result flag, always zero
);
	import glzw_pkg::*;

	logic [3:0]  min_q;
	logic [15:0] width_q, height_q, clip_q;
	logic [12:0] depth_q, next_slot_q, slot_limit_q;
	logic [19:0] buf_q;
	logic [4:0]  cnt_q;
	logic [7:0]  sub_q, first_q;
	logic [3:0]  bits_q;
	logic [11:0] prev_q, code_q, walk_q;
	logic        after_q, fin_q;
	logic [15:0] col_q, row_q;
	state_t      state_q, state_d;
	logic [13:0] res_q;
	logic        mval_q;

	logic [3:0]  em;
	logic [12:0] clear_c;
	assign em = eff_min(min_q);
	assign clear_c = 13'd1 << em;

	logic wr_cfg;
	assign wr_cfg = psel && penable && pwrite;
	assign pready = 1'b1;
	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_MIN:    prdata = {28'd0, min_q};
			REG_WIDTH:  prdata = {16'd0, width_q};
			REG_HEIGHT: prdata = {16'd0, height_q};
			REG_CLIP:   prdata = {16'd0, clip_q};
			default:    prdata = '0;
		endcase
	end

	// memory ports
	logic        dict_we, stk_we;
	logic [11:0] dict_waddr, dict_raddr, stk_waddr, stk_raddr, dict_rprefix, dict_wprefix;
	logic [7:0]  dict_wsuffix, dict_rsuffix, stk_wdata, stk_rdata;

	glzw_tables u_tables (
		.clk(clk), .dict_we(dict_we), .dict_waddr(dict_waddr), .dict_wprefix(dict_wprefix),
		.dict_wsuffix(dict_wsuffix), .dict_raddr(dict_raddr), .dict_rprefix(dict_rprefix),
		.dict_rsuffix(dict_rsuffix), .stk_we(stk_we), .stk_waddr(stk_waddr),
		.stk_wdata(stk_wdata), .stk_raddr(stk_raddr), .stk_rdata(stk_rdata)
	);

	assign s_tready = (state_q == ST_IDLE) && !mval_q;
	logic acc;
	assign acc = s_tvalid && s_tready;
	assign m_tvalid = mval_q;
	assign m_tdata = {2'b00, res_q};
	assign m_tuser = 1'b0;

	// current code from the bit buffer
	logic [11:0] code_c;
	logic        stack_full;
	assign code_c = 12'(buf_q & ((20'd1 << bits_q) - 20'd1));
	assign stack_full = depth_q[12];

	// column tagging for a popped pixel
	logic [15:0] col_inc;
	logic        rend;
	assign col_inc = col_q + 16'd1;
	assign rend = (col_inc >= width_q) || (col_inc == 16'd0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (acc) state_d = s_tuser ? ST_LOOP : ST_DONE;
			ST_LOOP: begin
				if (fin_q || depth_q != 13'd0 || cnt_q < {1'b0, bits_q}) state_d = ST_DONE;
				if (!fin_q && depth_q != 13'd0) state_d = ST_POPWAIT;
				else if (!fin_q && cnt_q >= {1'b0, bits_q} && code_c != 12'(clear_c)
				         && code_c != 12'(clear_c + 13'd1) && !after_q)
					state_d = ST_WALK;
				else if (!fin_q && cnt_q >= {1'b0, bits_q}) state_d = ST_LOOP;
			end
			ST_WALK:    state_d = ({1'b0, walk_q} >= clear_c + 13'd2 && !stack_full)
			                      ? ST_RDWAIT : ST_LOOP;
			ST_RDWAIT:  state_d = ST_WALK;
			ST_POPWAIT: state_d = ST_DONE;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory control
	logic walk_more;
	assign walk_more = ({1'b0, walk_q} >= clear_c + 13'd2) && !stack_full;
	always_comb begin
		dict_we = 1'b0;
		dict_waddr = next_slot_q[11:0];
		dict_wprefix = prev_q;
		dict_wsuffix = walk_q[7:0];
		dict_raddr = walk_q;
		stk_we = 1'b0;
		stk_waddr = depth_q[11:0];
		stk_wdata = walk_q[7:0];
		stk_raddr = depth_q[11:0] - 12'd1;
		case (state_q)
			ST_WALK: begin
				if (!walk_more) begin
					stk_we = !stack_full;
					dict_we = next_slot_q < slot_limit_q && !next_slot_q[12];
				end
			end
			ST_RDWAIT: begin
				stk_we = !stack_full;
				stk_wdata = dict_rsuffix;
			end
			ST_LOOP: begin
				stk_we = after_q && !fin_q && depth_q == 13'd0 && cnt_q >= {1'b0, bits_q}
				         && code_c != 12'(clear_c) && code_c != 12'(clear_c + 13'd1);
				stk_wdata = code_c[7:0];
				// KwKwK: push first char before the walk
				if (!after_q && !fin_q && depth_q == 13'd0 && cnt_q >= {1'b0, bits_q}
				    && code_c != 12'(clear_c) && code_c != 12'(clear_c + 13'd1)
				    && {1'b0, code_c} >= next_slot_q) begin
					stk_we = 1'b1;
					stk_wdata = first_q;
				end
			end
			default: ;
		endcase
	end

	logic [12:0] slot_inc;
	assign slot_inc = (dict_we) ? next_slot_q + 13'd1 : next_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			min_q <= 4'd8; width_q <= 16'd640; height_q <= 16'd480; clip_q <= 16'd640;
			depth_q <= '0; buf_q <= '0; cnt_q <= '0; sub_q <= '0;
			bits_q <= 4'd9; next_slot_q <= 13'd258; slot_limit_q <= 13'd512;
			prev_q <= '0; first_q <= '0; after_q <= 1'b0; col_q <= '0; row_q <= '0;
			fin_q <= 1'b0; mval_q <= 1'b0; res_q <= '0; code_q <= '0; walk_q <= '0;
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready) mval_q <= 1'b0;
			if (wr_cfg) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_MIN: begin
						min_q <= pwdata[3:0];
						bits_q <= eff_min(pwdata[3:0]) + 4'd1;
						next_slot_q <= (13'd1 << eff_min(pwdata[3:0])) + 13'd2;
						slot_limit_q <= 13'd1 << (eff_min(pwdata[3:0]) + 4'd1);
					end
					REG_WIDTH:  width_q <= pwdata[15:0];
					REG_HEIGHT: height_q <= pwdata[15:0];
					REG_CLIP:   clip_q <= pwdata[15:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (acc) begin
					// byte_taken: a length byte always, a data byte while room remains
					res_q <= {!s_tuser && (sub_q == 8'd0 || cnt_q <= 5'd12), 13'd0};
					if (!s_tuser) begin
						if (sub_q == 8'd0) begin
							sub_q <= s_tdata;
						end else if (cnt_q <= 5'd12) begin
							buf_q <= buf_q | (20'(s_tdata) << cnt_q);
							cnt_q <= cnt_q + 5'd8;
							sub_q <= sub_q - 8'd1;
						end
					end
				end
				ST_LOOP: begin
					if (!fin_q && depth_q == 13'd0) begin
						if (cnt_q < {1'b0, bits_q}) begin
							res_q[12] <= 1'b1;
						end else begin
							buf_q <= buf_q >> bits_q;
							cnt_q <= cnt_q - {1'b0, bits_q};
							if (code_c == 12'(clear_c + 13'd1)) begin
								fin_q <= 1'b1;
							end else if (code_c == 12'(clear_c)) begin
								bits_q <= em + 4'd1;
								next_slot_q <= clear_c + 13'd2;
								slot_limit_q <= clear_c << 1;
								after_q <= 1'b1;
							end else if (after_q) begin
								after_q <= 1'b0;
								prev_q <= code_c;
								first_q <= code_c[7:0];
								depth_q <= depth_q + 13'd1;
							end else begin
								code_q <= code_c;
								if ({1'b0, code_c} >= next_slot_q) begin
									walk_q <= prev_q;
									depth_q <= depth_q + 13'd1;
								end else begin
									walk_q <= code_c;
								end
							end
						end
					end
				end
				ST_RDWAIT: begin
					if (!stack_full) depth_q <= depth_q + 13'd1;
					walk_q <= dict_rprefix;
				end
				ST_WALK: if (!walk_more) begin
					walk_q <= {4'd0, walk_q[7:0]};
					if (!stack_full) depth_q <= depth_q + 13'd1;
					next_slot_q <= slot_inc;
					if (slot_inc >= slot_limit_q && bits_q < 4'(MaxCodeBits)) begin
						slot_limit_q <= slot_limit_q << 1;
						bits_q <= bits_q + 4'd1;
					end
					prev_q <= code_q & Mask12;
					first_q <= walk_q[7:0];
				end
				ST_POPWAIT: begin
					depth_q <= depth_q - 13'd1;
					res_q[10:0] <= {rend, col_q < clip_q, stk_rdata, 1'b1};
					col_q <= rend ? 16'd0 : col_inc;
					if (rend) begin
						row_q <= row_q + 16'd1;
						if (row_q + 16'd1 >= height_q) fin_q <= 1'b1;
					end
				end
				ST_DONE: begin
					res_q[11] <= fin_q;
					mval_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		mval_q |-> !s_tready) else $error("input taken while result pending");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POPWAIT |-> depth_q != 13'd0) else $error("pop from empty stack");
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= 4'(MaxCodeBits)) else $error("code size overflow");
endmodule

### rtl/glzw_tables.sv
// Dictionary memories (prefix and suffix) and the expansion stack of the decoder.
// Depends on glzw_pkg.
`timescale 1ns / 1ps
module glzw_tables (
	input  logic                      clk,
	input  logic                      dict_we,
	input  logic [glzw_pkg::AddrW-1:0] dict_waddr,
	input  logic [11:0]               dict_wprefix,
	input  logic [7:0]                dict_wsuffix,
	input  logic [glzw_pkg::AddrW-1:0] dict_raddr,
	output logic [11:0]               dict_rprefix,
	output logic [7:0]                dict_rsuffix,
	input  logic                      stk_we,
	input  logic [glzw_pkg::AddrW-1:0] stk_waddr,
	input  logic [7:0]                stk_wdata,
	input  logic [glzw_pkg::AddrW-1:0] stk_raddr,
	output logic [7:0]                stk_rdata
);
	import glzw_pkg::*;
	logic [11:0] prefix_mem [TableDepth];
	logic [7:0]  suffix_mem [TableDepth];
	logic [7:0]  stack_mem  [TableDepth];

	always_ff @(posedge clk) begin
		if (dict_we) begin
			prefix_mem[dict_waddr] <= dict_wprefix;
			suffix_mem[dict_waddr] <= dict_wsuffix;
		end
		dict_rprefix <= prefix_mem[dict_raddr];
		dict_rsuffix <= suffix_mem[dict_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		stk_rdata <= stack_mem[stk_raddr];
	end
endmodule
